[rtl/leb_pkg.sv]
// Package for the line edit buffer: buffer size, derived widths, operation
// and status codes, and the input and result item structs.
// No dependencies.
package leb_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int ADDR_W      = $clog2(BUFFER_SIZE);
    // width used to compare 8-bit request fields against the held count
    localparam int CMP_W       = (ADDR_W > 8) ? ADDR_W : 8;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_SETCUR = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] character;
        logic [7:0] remove_position;
        logic [7:0] new_cursor;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] line_length;
        logic [7:0] cursor_pos;
        logic [7:0] read_byte;
    } t_out_item;

endpackage

[rtl/line_edit_buffer.sv]
// Line edit buffer: 256-byte line store with cursor, insert/remove with tail
// shift, clear, set cursor and read back. Uses leb_pkg.
// One item at a time: the tail shift moves one byte per read state and write
// state pair through the single read and single write port of the line store.
// Reset (sync, active low) clears length, cursor and the handshake state; the
// line store is not cleared, since only bytes below the length are ever read.
module line_edit_buffer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  leb_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output leb_pkg::t_out_item o_out
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_RD  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_INS_PUT = 4'd3;
    localparam logic [3:0] S_REM_RD  = 4'd4;
    localparam logic [3:0] S_REM_WR  = 4'd5;
    localparam logic [3:0] S_REM_END = 4'd6;
    localparam logic [3:0] S_RD_WAIT = 4'd7;
    localparam logic [3:0] S_RD_GET  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [7:0] r_mem [leb_pkg::BUFFER_SIZE];
    logic [7:0] r_rdata;

    logic [3:0]                 r_state,  n_state;
    logic [leb_pkg::ADDR_W-1:0] r_count,  n_count;
    logic [leb_pkg::ADDR_W-1:0] r_cursor, n_cursor;
    logic [leb_pkg::ADDR_W-1:0] r_idx,    n_idx;
    logic [leb_pkg::ADDR_W-1:0] r_pos,    n_pos;
    logic [7:0]                 r_ch,     n_ch;
    logic [1:0]                 r_status, n_status;
    logic [7:0]                 r_rbyte,  n_rbyte;
    logic                       r_out_valid, n_out_valid;
    leb_pkg::t_out_item         r_out,    n_out;

    logic                       we;
    logic [leb_pkg::ADDR_W-1:0] waddr;
    logic [7:0]                 wdata;
    logic [leb_pkg::ADDR_W-1:0] raddr;
    logic [leb_pkg::ADDR_W-1:0] idx_dec, idx_inc;
    logic [leb_pkg::CMP_W-1:0]  cnt_x, rpos_x, ncur_x, ridx_x;

    assign idx_dec = r_idx - leb_pkg::ADDR_W'(1);
    assign idx_inc = r_idx + leb_pkg::ADDR_W'(1);
    assign raddr   = (r_state == S_INS_RD) ? idx_dec : r_idx;

    assign cnt_x  = leb_pkg::CMP_W'(r_count);
    assign rpos_x = leb_pkg::CMP_W'(i_in.remove_position);
    assign ncur_x = leb_pkg::CMP_W'(i_in.new_cursor);
    assign ridx_x = leb_pkg::CMP_W'(i_in.read_index);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // line store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_ch        = r_ch;
        n_status    = r_status;
        n_rbyte     = r_rbyte;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_status = leb_pkg::ST_OK;
                    n_rbyte  = 8'd0;
                    n_ch     = i_in.character;
                    n_state  = S_DONE;
                    case (i_in.operation)
                        leb_pkg::OP_INSERT: begin
                            if (32'(r_count) + 32'd1 >= 32'(leb_pkg::BUFFER_SIZE)) begin
                                n_status = leb_pkg::ST_FULL;
                            end else begin
                                n_idx   = r_count;
                                n_state = (r_count > r_cursor) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        leb_pkg::OP_REMOVE: begin
                            if (rpos_x == '0 || rpos_x > cnt_x) begin
                                n_status = leb_pkg::ST_RANGE;
                            end else begin
                                n_idx   = leb_pkg::ADDR_W'(rpos_x);
                                n_pos   = leb_pkg::ADDR_W'(rpos_x);
                                n_state = (rpos_x < cnt_x) ? S_REM_RD : S_REM_END;
                            end
                        end
                        leb_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_cursor = '0;
                        end
                        leb_pkg::OP_SETCUR: begin
                            n_cursor = (ncur_x > cnt_x) ? r_count
                                                        : leb_pkg::ADDR_W'(ncur_x);
                        end
                        leb_pkg::OP_READ: begin
                            if (ridx_x < cnt_x) begin
                                n_idx   = leb_pkg::ADDR_W'(ridx_x);
                                n_state = S_RD_WAIT;
                            end else begin
                                n_status = leb_pkg::ST_RANGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // shift right: store[i] = store[i-1] for i from length down to cursor+1
            S_INS_RD: n_state = S_INS_WR;
            S_INS_WR: begin
                we      = 1'b1;
                waddr   = r_idx;
                n_idx   = idx_dec;
                n_state = (idx_dec > r_cursor) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT: begin
                we       = 1'b1;
                waddr    = r_cursor;
                wdata    = r_ch;
                n_count  = r_count + leb_pkg::ADDR_W'(1);
                n_cursor = r_cursor + leb_pkg::ADDR_W'(1);
                n_state  = S_DONE;
            end
            // shift left: store[i-1] = store[i] for i from pos to length-1
            S_REM_RD: n_state = S_REM_WR;
            S_REM_WR: begin
                we      = 1'b1;
                waddr   = idx_dec;
                n_idx   = idx_inc;
                n_state = (idx_inc < r_count) ? S_REM_RD : S_REM_END;
            end
            S_REM_END: begin
                n_count = r_count - leb_pkg::ADDR_W'(1);
                if (r_pos <= r_cursor) begin
                    n_cursor = r_cursor - leb_pkg::ADDR_W'(1);
                end
                n_state = S_DONE;
            end
            S_RD_WAIT: n_state = S_RD_GET;
            S_RD_GET: begin
                n_rbyte = r_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.line_length = 8'(r_count);
                    n_out.cursor_pos  = 8'(r_cursor);
                    n_out.read_byte   = r_rbyte;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_ch     <= n_ch;
        r_status <= n_status;
        r_rbyte  <= n_rbyte;
        r_out    <= n_out;
    end

    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("cursor beyond line length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < leb_pkg::BUFFER_SIZE)
        else $error("length reached buffer size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item produced no work");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT) |=> (r_count == $past(r_count) + leb_pkg::ADDR_W'(1)))
        else $error("insert did not grow the line");

endmodule
